// ----- hdl/brf_pkg.sv -----
// Package for the circular byte FIFO: sizes, codes, beat types and helpers.
package brf_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = 11;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_PUSH_NOROOM = 2'd1,
		ST_POP_SHORT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		WC_ONE = 2'd0,
		WC_TWO = 2'd1
	} width_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_POP,
		S_POP_WAIT,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		logic [1:0]    op;
		logic [1:0]    width_code;
		logic [31:0]   write_data;
		logic [CW-1:0] request_bytes;
	} in_t;

	typedef struct packed {
		logic [31:0]   read_data;
		logic [1:0]    status;
		logic          has_room;
		logic [CW-1:0] fill_count;
		logic          is_empty;
	} out_t;

	// Step an index by one, wrapping at the capacity in use.
	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx,
			input logic [CW-1:0] cap);
		logic [CW-1:0] n;
		n = CW'(idx) + CW'(1);
		return (n >= cap) ? '0 : n[AW-1:0];
	endfunction

	// Clamp a written capacity into the range 1..DEPTH.
	function automatic logic [CW-1:0] eff_capacity(input logic [CW-1:0] value);
		if (value == '0)
			return CW'(1);
		if (value > CW'(DEPTH))
			return CW'(DEPTH);
		return value;
	endfunction

	function automatic logic [2:0] byte_count(input logic [1:0] wc);
		if (wc == WC_ONE)
			return 3'd1;
		if (wc == WC_TWO)
			return 3'd2;
		return 3'd4;
	endfunction

endpackage

// ----- hdl/byte_ring_fifo_multiwidth.sv -----
// Circular byte FIFO with run-time capacity and 1/2/4-byte push and pop.
// A push writes in S_PUSH, a pop reads in S_POP then S_POP_WAIT; these and clear,
// room query or a refused push or pop end in S_FINISH, which registers the strobe.
// The store moves one byte a cycle through its write or read port; the next start is
// taken on the strobe cycle. Reset: queue empty, head 0, tail capacity-1, capacity
// 1024; store contents are undefined and need no clearing pass. No result stall.
module byte_ring_fifo_multiwidth (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  brf_pkg::in_t        item,
	output logic                done,
	output brf_pkg::out_t       result,
	input  logic                cfg_we,
	input  logic [brf_pkg::CW-1:0] cfg_wdata
);

	logic [7:0] mem [brf_pkg::DEPTH];

	brf_pkg::fsm_t         state_q, state_d;
	logic [brf_pkg::AW-1:0] head_q, head_d, tail_q, tail_d;
	logic [brf_pkg::CW-1:0] count_q, count_d, cap_q, cap_d;
	logic [1:0]            cnt_q, cnt_d;
	logic [2:0]            nb_q, nb_d;
	logic [31:0]           wdata_q, wdata_d, rdata_q, rdata_d;
	logic [brf_pkg::CW-1:0] req_q, req_d;
	logic [1:0]            status_q, status_d;
	logic                  done_q, done_d;
	brf_pkg::out_t         result_q, result_d;

	logic                  we, re;
	logic [brf_pkg::AW-1:0] waddr, raddr;
	logic [7:0]            wbyte, rd_s1;
	logic                  rd_valid_s1;
	logic [1:0]            rd_idx_s1;
	logic [2:0]            nb_in;
	logic                  last;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wbyte;
		if (re)
			rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brf_pkg::S_IDLE;
			head_q      <= '0;
			tail_q      <= brf_pkg::AW'(brf_pkg::DEPTH - 1);
			count_q     <= '0;
			cap_q       <= brf_pkg::CW'(brf_pkg::DEPTH);
			cnt_q       <= '0;
			done_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			cap_q       <= cap_d;
			cnt_q       <= cnt_d;
			done_q      <= done_d;
			rd_valid_s1 <= re;
		end
	end

	always_ff @(posedge clk) begin
		nb_q      <= nb_d;
		wdata_q   <= wdata_d;
		rdata_q   <= rdata_d;
		req_q     <= req_d;
		status_q  <= status_d;
		result_q  <= result_d;
		rd_idx_s1 <= cnt_q;
	end

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		cap_d    = cap_q;
		cnt_d    = cnt_q;
		nb_d     = nb_q;
		wdata_d  = wdata_q;
		rdata_d  = rdata_q;
		req_d    = req_q;
		status_d = status_q;
		done_d   = 1'b0;
		result_d = result_q;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = brf_pkg::wrap_next(tail_q, cap_q);
		raddr    = head_q;
		wbyte    = wdata_q[8*cnt_q +: 8];
		nb_in    = brf_pkg::byte_count(item.width_code);
		last     = ({1'b0, cnt_q} == nb_q - 3'd1);

		// gather the byte that the store returned in the cycle after its read
		if (rd_valid_s1)
			rdata_d[8*rd_idx_s1 +: 8] = rd_s1;

		unique case (state_q)
			brf_pkg::S_IDLE: begin
				if (start) begin
					nb_d     = nb_in;
					wdata_d  = item.write_data;
					req_d    = item.request_bytes;
					rdata_d  = '0;
					status_d = brf_pkg::ST_DONE;
					cnt_d    = '0;
					state_d  = brf_pkg::S_FINISH;
					unique case (item.op)
						brf_pkg::OP_PUSH: begin
							if (cap_q - count_q >= brf_pkg::CW'(nb_in))
								state_d = brf_pkg::S_PUSH;
							else
								status_d = brf_pkg::ST_PUSH_NOROOM;
						end
						brf_pkg::OP_POP: begin
							if (count_q >= brf_pkg::CW'(nb_in))
								state_d = brf_pkg::S_POP;
							else
								status_d = brf_pkg::ST_POP_SHORT;
						end
						brf_pkg::OP_CLEAR: begin
							head_d  = '0;
							tail_d  = brf_pkg::AW'(cap_q - brf_pkg::CW'(1));
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			brf_pkg::S_PUSH: begin
				we     = 1'b1;
				tail_d = waddr;
				cnt_d  = cnt_q + 2'd1;
				if (last) begin
					count_d = count_q + brf_pkg::CW'(nb_q);
					state_d = brf_pkg::S_FINISH;
				end
			end
			brf_pkg::S_POP: begin
				re     = 1'b1;
				head_d = brf_pkg::wrap_next(head_q, cap_q);
				cnt_d  = cnt_q + 2'd1;
				if (last) begin
					count_d = count_q - brf_pkg::CW'(nb_q);
					state_d = brf_pkg::S_POP_WAIT;
				end
			end
			brf_pkg::S_POP_WAIT: begin
				// last byte lands in rdata this cycle
				state_d = brf_pkg::S_FINISH;
			end
			brf_pkg::S_FINISH: begin
				done_d              = 1'b1;
				result_d.read_data  = rdata_q;
				result_d.status     = status_q;
				result_d.has_room   = (cap_q - count_q) >= req_q;
				result_d.fill_count = count_q;
				result_d.is_empty   = (count_q == '0);
				state_d             = brf_pkg::S_IDLE;
			end
			default: state_d = brf_pkg::S_IDLE;
		endcase

		// a capacity write also empties the queue
		if (cfg_we) begin
			cap_d   = brf_pkg::eff_capacity(cfg_wdata);
			head_d  = '0;
			tail_d  = brf_pkg::AW'(cap_d - brf_pkg::CW'(1));
			count_d = '0;
		end
	end

	assign busy   = (state_q != brf_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- hdl/brf_checker.sv -----
// Port-level checks for the circular byte FIFO, bound to the top level.
module brf_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input brf_pkg::out_t          result
);

	// a result beat only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_empty == (result.fill_count == '0)))
		else $error("empty flag disagrees with fill count");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.fill_count <= brf_pkg::CW'(brf_pkg::DEPTH)))
		else $error("fill count above depth");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != brf_pkg::ST_DONE)) |-> (result.read_data == '0))
		else $error("refused beat carries data");

endmodule

bind byte_ring_fifo_multiwidth brf_checker u_brf_checker (.*);
